// File: hw/rtl/sfre_pkg.sv
// ---------------------------------------------------------------------------
// sfre_pkg: shared types and constants
// Depths, phase, protocol, timer, mode and cancel codes, register indexes, and the per-word result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfre_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ADDR     = 5'd1;
  localparam logic [4:0] PH_DATA     = 5'd2;
  localparam logic [4:0] PH_CKS      = 5'd3;
  localparam logic [4:0] PH_PEND     = 5'd4;
  localparam logic [4:0] PH_TXSTART  = 5'd5;
  localparam logic [4:0] PH_PL_DATA  = 5'd6;
  localparam logic [4:0] PH_PL_CR    = 5'd7;
  localparam logic [4:0] PH_PL_LF    = 5'd8;
  localparam logic [4:0] PH_X_ADDR   = 5'd9;
  localparam logic [4:0] PH_X_DATA   = 5'd10;
  localparam logic [4:0] PH_X_ETX    = 5'd11;
  localparam logic [4:0] PH_X_CKS    = 5'd12;
  localparam logic [4:0] PH_A_ADDR   = 5'd13;
  localparam logic [4:0] PH_A_DATA   = 5'd14;
  localparam logic [4:0] PH_A_CLOSE  = 5'd15;
  localparam logic [4:0] PH_A_CKS    = 5'd16;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_CR   = 2'd1;
  localparam logic [1:0] P_XOR  = 2'd2;
  localparam logic [1:0] P_ASC  = 2'd3;

  localparam logic [1:0] T_NONE   = 2'd0;
  localparam logic [1:0] T_START  = 2'd1;
  localparam logic [1:0] T_RETRIG = 2'd2;
  localparam logic [1:0] T_STOP   = 2'd3;

  localparam logic [2:0] M_RX     = 3'd0;
  localparam logic [2:0] M_PUT    = 3'd1;
  localparam logic [2:0] M_START  = 3'd2;
  localparam logic [2:0] M_NEXT   = 3'd3;
  localparam logic [2:0] M_READ   = 3'd4;
  localparam logic [2:0] M_CLEAR  = 3'd5;
  localparam logic [2:0] M_REWIND = 3'd6;

  localparam logic [2:0] C_NONE    = 3'd0;
  localparam logic [2:0] C_BADADDR = 3'd1;
  localparam logic [2:0] C_OVFL    = 3'd2;
  localparam logic [2:0] C_ASCCKS  = 3'd3;
  localparam logic [2:0] C_XORCKS  = 3'd4;
  localparam logic [2:0] C_NOPROT  = 3'd5;
  localparam logic [2:0] C_NOTOURS = 3'd6;

  localparam logic [0:0] REG_LINE_MODE = 1'b0;
  localparam logic [0:0] REG_OWN_ADDR  = 1'b1;

  typedef struct packed {
    logic [7:0] dout;
    logic       use_rx;
    logic       use_tx;
    logic       done;
    logic [2:0] cancel;
    logic [1:0] timer;
    logic       fin;
    logic       empty;
    logic [1:0] protocol;
    logic [5:0] address;
    logic [6:0] length;
  } result_t;

  // Printable checksum step: add (c - 0x20) and fold once by 95.
  function automatic logic [7:0] asc_add(input logic [7:0] acc, input logic [7:0] c);
    logic [7:0] v;
    v = acc + c - 8'h20;
    if (v >= 8'd95) v = v - 8'd95;
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfre_ram.sv
// ---------------------------------------------------------------------------
// sfre_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/sfre_core.sv
// ---------------------------------------------------------------------------
// sfre_core: frame sequencer
// Holds the phase, pointers and checksum; drives both buffer memories.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfre_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     accept,
  input  wire logic [2:0]               mode,
  input  wire logic [7:0]               data_in,
  input  wire logic                     line_mode,
  input  wire logic [5:0]               own_addr,
  input  wire logic [7:0]               tx_rd,
  output logic                          rx_we,
  output logic [sfre_pkg::RX_AW-1:0]    rx_wa,
  output logic                          rx_re,
  output logic [sfre_pkg::RX_AW-1:0]    rx_ra,
  output logic                          tx_we,
  output logic [sfre_pkg::TX_AW-1:0]    tx_wa,
  output logic                          tx_re,
  output logic [sfre_pkg::TX_AW-1:0]    tx_ra,
  output sfre_pkg::result_t             res
);
  import sfre_pkg::*;

  localparam logic [1:0] PD_NONE = 2'd0;
  localparam logic [1:0] PD_XOR  = 2'd1;
  localparam logic [1:0] PD_ASC  = 2'd2;

  logic [4:0] phase_r, phase_nxt;
  logic [1:0] proto_r, proto_nxt;
  logic [7:0] acc_r, acc_nxt, acc_eff;
  logic [5:0] faddr_r, faddr_nxt;
  logic [6:0] rxp_r, rxp_nxt, rxc_r, rxc_nxt;
  logic [8:0] txp_r, txp_nxt, txrem_r, txrem_nxt;
  logic [1:0] pend_r, pend_nxt;

  logic [4:0] ph_e;
  logic       tx_active, rx_end, addr_ok;
  logic [2:0] code;
  logic [7:0] b;

  // A transmitted data byte reaches the checksum only once the memory has
  // returned it; the next word sees the forwarded value.
  always_comb begin
    unique case (pend_r)
      PD_XOR:  acc_eff = acc_r ^ tx_rd;
      PD_ASC:  acc_eff = asc_add(acc_r, tx_rd);
      default: acc_eff = acc_r;
    endcase
  end

  function automatic logic [7:0] accum(input logic [1:0] p, input logic [7:0] a,
                                       input logic [7:0] c);
    if (p == P_ASC) return asc_add(a, c);
    else if (p == P_XOR) return a ^ c;
    else return a;
  endfunction

  assign tx_active = (phase_r >= PH_TXSTART);
  // A line's first byte always lands in entry 0.
  assign rx_wa = (phase_r == PH_IDLE || phase_r == PH_PEND) ? '0 : rxp_r[RX_AW-1:0];
  assign rx_ra = rxp_r[RX_AW-1:0];
  assign tx_wa = txp_r[TX_AW-1:0];
  assign tx_ra = txp_r[TX_AW-1:0];

  always_comb begin
    phase_nxt = phase_r; proto_nxt = proto_r; acc_nxt = acc_eff;
    faddr_nxt = faddr_r; rxp_nxt = rxp_r; rxc_nxt = rxc_r;
    txp_nxt = txp_r; txrem_nxt = txrem_r; pend_nxt = PD_NONE;
    rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
    rx_end = 1'b0; code = C_NONE; addr_ok = 1'b0; b = 8'h00; ph_e = phase_r;
    res = '0;

    unique case (mode)
      M_RX: begin
        unique case (phase_r)
          PH_IDLE, PH_PEND: begin
            acc_nxt = 8'h00;
            if (data_in == 8'h7B || data_in == 8'h02) begin
              proto_nxt = (data_in == 8'h7B) ? P_ASC : P_XOR;
              phase_nxt = PH_ADDR;
              rxp_nxt   = '0;
              acc_nxt   = (data_in == 8'h7B) ? asc_add(8'h00, data_in) : data_in;
              res.timer = T_START;
            end else if (!line_mode) begin
              res.timer = T_STOP;
            end else begin
              rx_we     = 1'b1;
              rxp_nxt   = 7'd1;
              proto_nxt = P_CR;
              phase_nxt = PH_DATA;
              res.timer = T_RETRIG;
            end
          end
          PH_ADDR: begin
            if (proto_r == P_ASC && data_in >= 8'h40 && data_in < 8'h80) begin
              addr_ok = 1'b1; faddr_nxt = 6'(data_in - 8'h40);
            end else if (proto_r == P_XOR && data_in >= 8'h30 && data_in < 8'h70) begin
              addr_ok = 1'b1; faddr_nxt = 6'(data_in - 8'h30);
            end
            if (addr_ok) begin
              phase_nxt = PH_DATA;
              acc_nxt   = accum(proto_r, acc_eff, data_in);
              res.timer = T_RETRIG;
            end else begin
              rx_end = 1'b1; code = C_BADADDR;
            end
          end
          PH_DATA: begin
            if ((proto_r == P_CR && data_in == 8'h0D) ||
                (proto_r == P_XOR && data_in == 8'h03) ||
                (proto_r == P_ASC && data_in == 8'h7D)) begin
              if (proto_r == P_CR) begin
                rx_end = 1'b1;
              end else begin
                phase_nxt = PH_CKS;
                acc_nxt   = accum(proto_r, acc_eff, data_in);
                res.timer = T_RETRIG;
              end
            end else if (rxp_r >= 7'(RX_DEPTH)) begin
              rx_end = 1'b1; code = C_OVFL;
            end else begin
              rx_we     = 1'b1;
              rxp_nxt   = rxp_r + 7'd1;
              acc_nxt   = accum(proto_r, acc_eff, data_in);
              res.timer = T_RETRIG;
            end
          end
          PH_CKS: begin
            rx_end = 1'b1;
            if (proto_r == P_ASC) begin
              if (data_in < 8'h20 || acc_eff != data_in - 8'h20) code = C_ASCCKS;
            end else if (proto_r == P_XOR) begin
              if (acc_eff != data_in) code = C_XORCKS;
            end else begin
              code = C_NOPROT;
            end
            if (faddr_r != 6'd0 && faddr_r != own_addr) code = C_NOTOURS;
          end
          default: ;
        endcase
        if (rx_end) begin
          res.timer = T_STOP;
          if (code != C_NONE) begin
            res.cancel = code;
            proto_nxt = P_NONE; phase_nxt = PH_IDLE; rxp_nxt = '0; acc_nxt = 8'h00;
          end else begin
            res.done = 1'b1;
            rxc_nxt = rxp_r; rxp_nxt = '0; phase_nxt = PH_PEND;
          end
        end
      end
      M_PUT: begin
        if (!tx_active && txp_r < 9'(TX_DEPTH)) begin
          tx_we = 1'b1; txp_nxt = txp_r + 9'd1;
        end
      end
      M_START: begin
        phase_nxt = PH_TXSTART; txrem_nxt = txp_r; txp_nxt = '0;
      end
      M_NEXT: begin
        if (tx_active) begin
          // Resolve the phases that emit nothing before picking a character.
          if (ph_e == PH_TXSTART && proto_r != P_XOR && proto_r != P_ASC)
            ph_e = PH_PL_DATA;
          if (txrem_r == 9'd0) begin
            if (ph_e == PH_PL_DATA) ph_e = PH_PL_CR;
            else if (ph_e == PH_X_DATA) ph_e = PH_X_ETX;
            else if (ph_e == PH_A_DATA) ph_e = PH_A_CLOSE;
          end
          unique case (ph_e)
            PH_TXSTART: begin
              if (proto_r == P_XOR) begin
                phase_nxt = PH_X_ADDR; acc_nxt = 8'h05; res.dout = 8'h06;
              end else begin
                phase_nxt = PH_A_ADDR; acc_nxt = 8'd89; res.dout = 8'h7B;
              end
            end
            PH_PL_DATA, PH_X_DATA, PH_A_DATA: begin
              tx_re      = (txp_r < 9'(TX_DEPTH));
              res.use_tx = tx_re;
              txp_nxt    = txp_r + 9'd1;
              txrem_nxt  = txrem_r - 9'd1;
              if (ph_e == PH_X_DATA) pend_nxt = PD_XOR;
              else if (ph_e == PH_A_DATA) pend_nxt = PD_ASC;
              phase_nxt  = ph_e;
              if (txrem_r == 9'd1) begin
                if (ph_e == PH_PL_DATA) phase_nxt = PH_PL_CR;
                else if (ph_e == PH_X_DATA) phase_nxt = PH_X_ETX;
                else phase_nxt = PH_A_CLOSE;
              end
            end
            PH_PL_CR: begin phase_nxt = PH_PL_LF; res.dout = 8'h0D; end
            PH_PL_LF: begin phase_nxt = PH_IDLE; res.fin = 1'b1; res.dout = 8'h0A; end
            PH_X_ADDR: begin
              b = {2'b00, own_addr} + 8'h30;
              phase_nxt = PH_X_DATA; acc_nxt = acc_eff ^ b; res.dout = b;
            end
            PH_X_ETX: begin phase_nxt = PH_X_CKS; res.dout = 8'h03; end
            PH_X_CKS: begin phase_nxt = PH_IDLE; res.fin = 1'b1; res.dout = acc_eff; end
            PH_A_ADDR: begin
              b = {2'b00, own_addr} + 8'h40;
              phase_nxt = PH_A_DATA; acc_nxt = asc_add(acc_eff, b); res.dout = b;
            end
            PH_A_CLOSE: begin phase_nxt = PH_A_CKS; res.dout = 8'h7D; end
            PH_A_CKS: begin
              phase_nxt = PH_IDLE; res.fin = 1'b1;
              b = (acc_eff >= 8'd95) ? acc_eff - 8'd95 : acc_eff;
              acc_nxt = b;
              res.dout = b + 8'h20;
            end
            default: ;
          endcase
        end
      end
      M_READ: begin
        if (phase_r == PH_ADDR || phase_r == PH_DATA || phase_r == PH_CKS ||
            rxp_r >= rxc_r || rxp_r >= 7'(RX_DEPTH)) begin
          res.empty = 1'b1;
        end else begin
          rx_re = 1'b1; res.use_rx = 1'b1; rxp_nxt = rxp_r + 7'd1;
        end
      end
      M_CLEAR: begin
        proto_nxt = P_NONE; phase_nxt = PH_IDLE; rxp_nxt = '0; acc_nxt = 8'h00;
        res.timer = T_STOP;
      end
      M_REWIND: rxp_nxt = '0;
      default: ;
    endcase

    res.protocol = proto_nxt;
    res.address  = faddr_nxt;
    res.length   = rxc_nxt;
    if (!accept) begin
      rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; proto_r <= P_NONE; acc_r <= 8'h00; faddr_r <= 6'd0;
      rxp_r <= '0; rxc_r <= '0; txp_r <= '0; txrem_r <= '0; pend_r <= PD_NONE;
    end else if (accept) begin
      phase_r <= phase_nxt; proto_r <= proto_nxt; acc_r <= acc_nxt;
      faddr_r <= faddr_nxt; rxp_r <= rxp_nxt; rxc_r <= rxc_nxt;
      txp_r <= txp_nxt; txrem_r <= txrem_nxt; pend_r <= pend_nxt;
    end else begin
      acc_r  <= acc_eff;
      pend_r <= PD_NONE;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/serial_frame_rx_tx_engine.sv
// ---------------------------------------------------------------------------
// serial_frame_rx_tx_engine: addressed serial frame receiver and transmitter
// Checks and stores received frames, frames queued bytes for transmission.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_stall    in_mode, in_data_in
//  out      out_valid / out_stall  out_data_out ... out_read_empty
//  config   psel/penable/pwrite    paddr, pwdata, prdata
//
// One word is taken per cycle while in_stall is low. A word's result passes the
// first stage and the output register: the buffer memory read and the first
// stage load at the accepting edge, the output register when it advances.
// Reset clears all control state; buffers are not cleared.
// A stalled output holds its word and one more in the first stage, then
// in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_rx_tx_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_data_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_data_out,
  output logic             out_message_done,
  output logic [2:0]       out_cancel_code,
  output logic [1:0]       out_timer_command,
  output logic             out_tx_finished,
  output logic [1:0]       out_protocol,
  output logic [5:0]       out_rx_address,
  output logic [6:0]       out_rx_length,
  output logic             out_read_empty,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfre_pkg::*;

  logic       line_mode_r;
  logic [5:0] own_addr_r;
  logic       accept, s1_v_r, o_v_r, o_adv;
  result_t    res, s1_r;
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [RX_AW-1:0] rx_wa, rx_ra;
  logic [TX_AW-1:0] tx_wa, tx_ra;
  logic [7:0] rx_rd, tx_rd;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_LINE_MODE: prdata = {31'd0, line_mode_r};
      default:       prdata = {26'd0, own_addr_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= 1'b0;
      own_addr_r  <= 6'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_LINE_MODE) line_mode_r <= pwdata[0];
      else own_addr_r <= pwdata[5:0];
    end
  end

  assign o_adv    = s1_v_r && (!o_v_r || !out_stall);
  assign in_stall = s1_v_r && !o_adv;
  assign accept   = in_valid && !in_stall;
  assign out_valid = o_v_r;

  sfre_core u_core (
    .clk, .rst_n, .accept, .mode(in_mode), .data_in(in_data_in),
    .line_mode(line_mode_r), .own_addr(own_addr_r), .tx_rd,
    .rx_we, .rx_wa, .rx_re, .rx_ra, .tx_we, .tx_wa, .tx_re, .tx_ra, .res
  );

  sfre_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk, .we(rx_we), .waddr(rx_wa), .wdata(in_data_in),
    .re(rx_re), .raddr(rx_ra), .rdata(rx_rd)
  );

  sfre_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk, .we(tx_we), .waddr(tx_wa), .wdata(in_data_in),
    .re(tx_re), .raddr(tx_ra), .rdata(tx_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (accept) s1_v_r <= 1'b1;
      else if (o_adv) s1_v_r <= 1'b0;
      if (o_adv) o_v_r <= 1'b1;
      else if (!out_stall) o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_r <= res;
    if (o_adv) begin
      out_data_out      <= s1_r.use_rx ? rx_rd : (s1_r.use_tx ? tx_rd : s1_r.dout);
      out_message_done  <= s1_r.done;
      out_cancel_code   <= s1_r.cancel;
      out_timer_command <= s1_r.timer;
      out_tx_finished   <= s1_r.fin;
      out_protocol      <= s1_r.protocol;
      out_rx_address    <= s1_r.address;
      out_rx_length     <= s1_r.length;
      out_read_empty    <= s1_r.empty;
    end
  end
endmodule
`default_nettype wire

// File: bench/sfre_checker.sv
// ---------------------------------------------------------------------------
// sfre_checker: result predictor and comparator for the frame engine
// Watches both word channels and the register port, predicts each result
// word from an internal copy of the engine state, and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sfre_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_data_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_data_out,
  input  logic        out_message_done,
  input  logic [2:0]  out_cancel_code,
  input  logic [1:0]  out_timer_command,
  input  logic        out_tx_finished,
  input  logic [1:0]  out_protocol,
  input  logic [5:0]  out_rx_address,
  input  logic [6:0]  out_rx_length,
  input  logic        out_read_empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import sfre_pkg::*;

  typedef struct packed {
    logic [7:0] dout;
    logic       done;
    logic [2:0] cancel;
    logic [1:0] timer;
    logic       fin;
    logic [1:0] proto;
    logic [5:0] addr;
    logic [6:0] len;
    logic       empty;
  } word_result_t;

  word_result_t expected_q[$];

  logic       line_en;
  logic [5:0] own_addr;
  logic [4:0] phase;
  logic [1:0] proto;
  logic [7:0] acc;
  logic [5:0] frame_addr;
  logic [6:0] rx_ptr, rx_cnt;
  logic [8:0] tx_ptr, tx_left;
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  assign pending = expected_q.size();

  function automatic logic [7:0] fold_printable(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] v;
    v = a + (c - 8'h20);
    return (v >= 8'd95) ? v - 8'd95 : v;
  endfunction

  function automatic void sum_in(input logic [7:0] c);
    if (proto == P_ASC) acc = fold_printable(acc, c);
    else if (proto == P_XOR) acc = acc ^ c;
  endfunction

  function automatic void rx_clear();
    proto = P_NONE;
    phase = PH_IDLE;
    rx_ptr = '0;
    acc = '0;
  endfunction

  function automatic void rx_step(input logic [7:0] c, inout word_result_t r);
    logic [2:0] code;
    logic       closing;
    code = C_NONE;
    closing = 1'b0;
    case (phase)
      PH_IDLE, PH_PEND: begin
        acc = '0;
        if (c == 8'h7B || c == 8'h02) begin
          proto = (c == 8'h7B) ? P_ASC : P_XOR;
          phase = PH_ADDR;
          rx_ptr = '0;
          sum_in(c);
          r.timer = T_START;
        end else if (!line_en) begin
          r.timer = T_STOP;
        end else begin
          rx_mem[0] = c;
          rx_ptr = 7'd1;
          proto = P_CR;
          phase = PH_DATA;
          r.timer = T_RETRIG;
        end
      end
      PH_ADDR: begin
        if (proto == P_ASC && c >= 8'h40 && c < 8'h80) begin
          frame_addr = 6'(c - 8'h40);
        end else if (proto == P_XOR && c >= 8'h30 && c < 8'h70) begin
          frame_addr = 6'(c - 8'h30);
        end else begin
          code = C_BADADDR;
          closing = 1'b1;
        end
        if (!closing) begin
          phase = PH_DATA;
          sum_in(c);
          r.timer = T_RETRIG;
        end
      end
      PH_DATA: begin
        if ((proto == P_CR && c == 8'h0D) || (proto == P_XOR && c == 8'h03) ||
            (proto == P_ASC && c == 8'h7D)) begin
          if (proto == P_CR) begin
            closing = 1'b1;
          end else begin
            phase = PH_CKS;
            sum_in(c);
            r.timer = T_RETRIG;
          end
        end else if (rx_ptr >= RX_DEPTH) begin
          code = C_OVFL;
          closing = 1'b1;
        end else begin
          rx_mem[rx_ptr[5:0]] = c;
          rx_ptr = rx_ptr + 7'd1;
          sum_in(c);
          r.timer = T_RETRIG;
        end
      end
      PH_CKS: begin
        if (proto == P_ASC) begin
          if (c < 8'h20 || acc != c - 8'h20) code = C_ASCCKS;
        end else if (proto == P_XOR) begin
          if (acc != c) code = C_XORCKS;
        end else begin
          code = C_NOPROT;
        end
        if (frame_addr != 6'd0 && frame_addr != own_addr) code = C_NOTOURS;
        closing = 1'b1;
      end
      default: ;
    endcase
    if (closing) begin
      r.timer = T_STOP;
      if (code != C_NONE) begin
        r.cancel = code;
        rx_clear();
      end else begin
        r.done = 1'b1;
        rx_cnt = rx_ptr;
        rx_ptr = '0;
        phase = PH_PEND;
      end
    end
  endfunction

  function automatic logic [7:0] tx_pop();
    logic [7:0] b;
    b = (tx_ptr < TX_DEPTH) ? tx_mem[tx_ptr[7:0]] : 8'h00;
    tx_ptr = tx_ptr + 9'd1;
    tx_left = tx_left - 9'd1;
    return b;
  endfunction

  // Phases that emit nothing fall through to the next one within the same word.
  function automatic logic [7:0] tx_char(output logic fin);
    logic [7:0] b;
    logic       got;
    b = 8'h00;
    fin = 1'b0;
    got = 1'b0;
    repeat (3) begin
      if (!got) begin
        got = 1'b1;
        case (phase)
          PH_TXSTART: begin
            if (proto == P_XOR) begin
              phase = PH_X_ADDR; acc = 8'h06 ^ 8'h03; b = 8'h06;
            end else if (proto == P_ASC) begin
              phase = PH_A_ADDR; acc = 8'd89; b = 8'h7B;
            end else begin
              phase = PH_PL_DATA; got = 1'b0;
            end
          end
          PH_PL_DATA: begin
            if (tx_left == 0) begin
              phase = PH_PL_CR; got = 1'b0;
            end else begin
              b = tx_pop();
              if (tx_left == 0) phase = PH_PL_CR;
            end
          end
          PH_PL_CR: begin phase = PH_PL_LF; b = 8'h0D; end
          PH_PL_LF: begin phase = PH_IDLE; fin = 1'b1; b = 8'h0A; end
          PH_X_ADDR: begin
            phase = PH_X_DATA; b = {2'b00, own_addr} + 8'h30; acc = acc ^ b;
          end
          PH_X_DATA: begin
            if (tx_left == 0) begin
              phase = PH_X_ETX; got = 1'b0;
            end else begin
              b = tx_pop();
              acc = acc ^ b;
              if (tx_left == 0) phase = PH_X_ETX;
            end
          end
          PH_X_ETX: begin phase = PH_X_CKS; b = 8'h03; end
          PH_X_CKS: begin phase = PH_IDLE; fin = 1'b1; b = acc; end
          PH_A_ADDR: begin
            phase = PH_A_DATA; b = {2'b00, own_addr} + 8'h40; acc = fold_printable(acc, b);
          end
          PH_A_DATA: begin
            if (tx_left == 0) begin
              phase = PH_A_CLOSE; got = 1'b0;
            end else begin
              b = tx_pop();
              acc = fold_printable(acc, b);
              if (tx_left == 0) phase = PH_A_CLOSE;
            end
          end
          PH_A_CLOSE: begin phase = PH_A_CKS; b = 8'h7D; end
          PH_A_CKS: begin
            phase = PH_IDLE; fin = 1'b1;
            if (acc >= 8'd95) acc = acc - 8'd95;
            b = acc + 8'h20;
          end
          default: ;
        endcase
      end
    end
    return b;
  endfunction

  function automatic word_result_t predict_word(input logic [2:0] m, input logic [7:0] c);
    word_result_t r;
    logic         tx_on;
    logic         f;
    r = '0;
    tx_on = (phase >= PH_TXSTART);
    case (m)
      M_RX: rx_step(c, r);
      M_PUT: begin
        if (!tx_on && tx_ptr < TX_DEPTH) begin
          tx_mem[tx_ptr[7:0]] = c;
          tx_ptr = tx_ptr + 9'd1;
        end
      end
      M_START: begin
        phase = PH_TXSTART;
        tx_left = tx_ptr;
        tx_ptr = '0;
      end
      M_NEXT: begin
        if (tx_on) begin
          r.dout = tx_char(f);
          r.fin = f;
        end
      end
      M_READ: begin
        if (phase == PH_ADDR || phase == PH_DATA || phase == PH_CKS ||
            rx_ptr >= rx_cnt || rx_ptr >= RX_DEPTH) begin
          r.empty = 1'b1;
        end else begin
          r.dout = rx_mem[rx_ptr[5:0]];
          rx_ptr = rx_ptr + 7'd1;
        end
      end
      M_CLEAR: begin
        rx_clear();
        r.timer = T_STOP;
      end
      M_REWIND: rx_ptr = '0;
      default: ;
    endcase
    r.proto = proto;
    r.addr = frame_addr;
    r.len = rx_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    word_result_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      fail_count <= 0;
      line_en = 1'b0;
      own_addr = 6'd1;
      phase = PH_IDLE;
      proto = P_NONE;
      acc = '0;
      frame_addr = '0;
      rx_ptr = '0;
      rx_cnt = '0;
      tx_ptr = '0;
      tx_left = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_OWN_ADDR) own_addr = pwdata[5:0];
        else line_en = pwdata[0];
      end
      if (out_valid && !out_stall) begin
        got = '{out_data_out, out_message_done, out_cancel_code, out_timer_command,
                out_tx_finished, out_protocol, out_rx_address, out_rx_length,
                out_read_empty};
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: result word with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"ERROR: word mismatch exp/got data %h/%h done %b/%b cancel %0d/%0d",
                        " timer %0d/%0d fin %b/%b proto %0d/%0d addr %0d/%0d len %0d/%0d",
                        " empty %b/%b"},
                       want.dout, got.dout, want.done, got.done, want.cancel, got.cancel,
                       want.timer, got.timer, want.fin, got.fin, want.proto, got.proto,
                       want.addr, got.addr, want.len, got.len, want.empty, got.empty);
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_word(in_mode, in_data_in));
    end
  end

endmodule

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the serial frame engine
// Drives received frames, transmit sessions and store reads under three
// stall profiles and several register settings; the checker judges results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import sfre_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = M_REWIND;
  logic [7:0]  in_data_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_message_done;
  logic [2:0]  out_cancel_code;
  logic [1:0]  out_timer_command;
  logic        out_tx_finished;
  logic [1:0]  out_protocol;
  logic [5:0]  out_rx_address;
  logic [6:0]  out_rx_length;
  logic        out_read_empty;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          words_sent = 0;
  logic        line_on = 1'b0;
  logic [5:0]  my_addr = 6'd1;

  serial_frame_rx_tx_engine dut (.*);

  sfre_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < recv_idle_pct);

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input logic [2:0] m, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_data_in = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] v);
    in_valid = 1'b0;
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 3'(4 * idx);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Waits until every predicted word has come back, then lets the pipe settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_regs(input logic line, input logic [5:0] a);
    drain();
    write_reg(REG_LINE_MODE, {31'd0, line});
    write_reg(REG_OWN_ADDR, {26'd0, a});
    line_on = line;
    my_addr = a;
  endtask

  // kind: 0 brace frame, 1 STX frame, 2 CR line.
  // flaw: 0 none, 1 bad checksum, 2 bad address byte, 3 overflow.
  task automatic send_frame(input int kind, input int flaw, input int len, input int cut);
    logic [7:0] body[$];
    logic [7:0] b, sum, term;
    logic [5:0] a;
    int         r, n;
    r = $urandom_range(9);
    a = (r < 6) ? my_addr : (r < 8) ? 6'd0 : 6'($urandom);
    n = (flaw == 3) ? RX_DEPTH + 1 : len;
    term = (kind == 0) ? 8'h7D : (kind == 1) ? 8'h03 : 8'h0D;
    if (kind == 2) begin
      do b = 8'($urandom); while (b == 8'h7B || b == 8'h02);
      body.push_back(b);
    end else begin
      body.push_back((kind == 0) ? 8'h7B : 8'h02);
      if (flaw == 2) body.push_back((kind == 0) ? 8'($urandom_range(63)) :
                                                  8'($urandom_range(8'h70, 8'hFF)));
      else body.push_back({2'b00, a} + ((kind == 0) ? 8'h40 : 8'h30));
    end
    if (flaw != 2) begin
      for (int i = 0; i < n; i++) begin
        do b = 8'($urandom); while (b == term);
        body.push_back(b);
      end
      if (flaw != 3) begin
        body.push_back(term);
        if (kind != 2) begin
          sum = 8'h00;
          foreach (body[i]) begin
            if (kind == 1) sum = sum ^ body[i];
            else begin
              sum = sum + (body[i] - 8'h20);
              if (sum >= 8'd95) sum = sum - 8'd95;
            end
          end
          if (kind == 0) sum = sum + 8'h20;
          if (flaw == 1) begin
            if (kind == 0 && $urandom_range(1)) sum = 8'($urandom_range(31));
            else sum = sum ^ (8'd1 << $urandom_range(7));
          end
          body.push_back(sum);
        end
      end
    end
    foreach (body[i]) if (cut == 0 || i < cut) send_word(M_RX, body[i]);
  endtask

  task automatic tx_session(input int n);
    for (int i = 0; i < n; i++) send_word(M_PUT, 8'($urandom));
    send_word(M_START, 8'($urandom));
    for (int i = 0; i < n + 5; i++) begin
      if ($urandom_range(19) == 0) send_word(M_RX, 8'($urandom));
      else send_word(M_NEXT, 8'($urandom));
    end
  endtask

  task automatic read_burst();
    if ($urandom_range(1)) send_word(M_REWIND, 8'($urandom));
    repeat ($urandom_range(1, 8)) send_word(M_READ, 8'($urandom));
  endtask

  task automatic random_phase(input int target);
    int stop_at, r, kind;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      kind = line_on ? $urandom_range(2) : $urandom_range(1);
      if (r < 45) send_frame(kind, ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0,
                             $urandom_range(0, 6), 0);
      else if (r < 48) send_frame(kind, 3, 0, 0);
      else if (r < 55) send_frame(kind, 0, $urandom_range(1, 6), $urandom_range(1, 4));
      else if (r < 68) tx_session($urandom_range(0, 6));
      else if (r < 82) read_burst();
      else if (r < 88) send_word(M_CLEAR, 8'($urandom));
      else send_word(3'($urandom_range(0, 6)), 8'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: ignored idle byte, short frames in both framings, reads past
    // the end, full-range puts, a framed transmit and a clear.
    send_word(M_RX, 8'h41);
    send_word(M_READ, 8'h00);
    send_word(M_RX, 8'h7B);
    send_word(M_RX, 8'h41);
    send_word(M_RX, 8'hFF);
    send_word(M_RX, 8'h7D);
    send_word(M_RX, 8'h20 + 8'd70);
    send_word(M_READ, 8'hFF);
    send_word(M_READ, 8'h00);
    send_word(M_REWIND, 8'h00);
    send_word(M_READ, 8'h00);
    send_word(M_RX, 8'h02);
    send_word(M_RX, 8'h30);
    send_word(M_RX, 8'h03);
    send_word(M_RX, 8'h02 ^ 8'h30 ^ 8'h03);
    send_word(M_PUT, 8'h00);
    send_word(M_PUT, 8'hFF);
    send_word(M_START, 8'h00);
    repeat (6) send_word(M_NEXT, 8'h00);
    send_word(M_CLEAR, 8'h00);

    set_regs(1'b1, 6'd63);
    send_idle_pct = 17;
    recv_idle_pct = 56;
    random_phase(65);

    set_regs(1'b0, 6'd0);
    send_idle_pct = 56;
    recv_idle_pct = 17;
    random_phase(65);

    set_regs(1'b1, 6'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    tx_session(TX_DEPTH + 2);
    random_phase(65);

    drain();
    $display("summary: %0d words over three stall profiles, line mode on and off,", words_sent);
    $display("summary: own address 0, 63 and random, frames, transmits and store reads");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
